>>> rtl/stbs_pkg.sv
// Shared types and constants for the sorted-table binary search block.
// Used via scoped names by rtl/ files but stbs_ram; depends on nothing.
`default_nettype none

package stbs_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 256;
  localparam int KEY_WIDTH   = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  // Input command codes.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr;    // write one table entry
    logic load;  // start a search: latch key, count and bounds
    logic step;  // narrow the bounds after a probe
    logic emit;  // register the result
  } stbs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;   // current probe matches the key
    logic miss;  // search ends without a match
  } stbs_sts_t;

endpackage

`default_nettype wire

>>> rtl/stbs_ram.sv
// Generic single-port RAM with registered read data.
// Stand-alone; holds the sorted key table.
`default_nettype none

module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write (we) and one read per cycle; read data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> rtl/stbs_ctrl.sv
// Controller state machine for the sorted-table binary search.
// Depends on stbs_pkg for the command and status structs.
`default_nettype none

module stbs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                command,
  input  wire stbs_pkg::stbs_sts_t sts,
  output logic                     busy,
  output stbs_pkg::stbs_cmd_t      cmd,
  output logic                     strobe
);

  localparam logic [0:0] ST_IDLE   = 1'b0;
  localparam logic [0:0] ST_SEARCH = 1'b1;

  logic [0:0] state_r, state_nxt;
  logic       strobe_r, strobe_nxt;
  logic       accept;

  assign busy   = (state_r == ST_SEARCH);
  assign accept = start && !busy;
  assign strobe = strobe_r;

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.wr   = accept && (command == stbs_pkg::CMD_WRITE);
        cmd.load = accept && (command == stbs_pkg::CMD_SEARCH);
        if (cmd.load) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts.hit || sts.miss) begin
          cmd.emit   = 1'b1;
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and result strobe registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/stbs_dp.sv
// Datapath for the sorted-table binary search: table RAM, bounds, compare.
// Depends on stbs_pkg and instantiates stbs_ram.
`default_nettype none

module stbs_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire stbs_pkg::stbs_cmd_t             cmd,
  output stbs_pkg::stbs_sts_t                  sts,
  input  wire logic [stbs_pkg::IDX_W-1:0]      entry_index,
  input  wire logic [stbs_pkg::KEY_WIDTH-1:0]  key_value,
  input  wire logic                            cfg_wr_en,
  input  wire logic [stbs_pkg::CNT_W-1:0]      cfg_wr_data,
  output logic                                 found,
  output logic [stbs_pkg::CNT_W-1:0]           position
);

  logic [stbs_pkg::CNT_W-1:0]     entries_r;
  logic [stbs_pkg::CNT_W-1:0]     count_sat;
  logic [stbs_pkg::CNT_W-1:0]     count_r;
  logic                           empty_r;
  logic [stbs_pkg::KEY_WIDTH-1:0] key_r;
  logic [stbs_pkg::IDX_W-1:0]     left_r, left_nxt;
  logic [stbs_pkg::IDX_W-1:0]     right_r, right_nxt;
  logic [stbs_pkg::IDX_W-1:0]     mid_r;
  logic [stbs_pkg::IDX_W:0]       mid_sum;
  logic [stbs_pkg::IDX_W-1:0]     ram_addr;
  logic [stbs_pkg::KEY_WIDTH-1:0] rdata;
  logic                           gt;
  logic                           found_r;
  logic [stbs_pkg::CNT_W-1:0]     position_r;

  // Entry count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH);
    end else if (cfg_wr_en) begin
      entries_r <= cfg_wr_data;
    end
  end

  // Counts above the table depth are clamped to it.
  assign count_sat = (entries_r > stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH))
                   ? stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH) : entries_r;

  // Probe compare against the data read at mid_r.
  assign gt       = (rdata > key_r);
  assign sts.hit  = !empty_r && (rdata == key_r);
  assign sts.miss = empty_r || (!sts.hit &&
                    ((gt && (left_r == mid_r)) || (!gt && (mid_r == right_r))));

  // Bounds for the next probe: fresh at load, narrowed on each step.
  always_comb begin
    if (cmd.load) begin
      left_nxt  = '0;
      right_nxt = stbs_pkg::IDX_W'(count_sat - stbs_pkg::CNT_W'(1));
    end else if (gt) begin
      left_nxt  = left_r;
      right_nxt = mid_r - stbs_pkg::IDX_W'(1);
    end else begin
      left_nxt  = mid_r + stbs_pkg::IDX_W'(1);
      right_nxt = right_r;
    end
  end

  assign mid_sum  = {1'b0, left_nxt} + {1'b0, right_nxt};
  assign ram_addr = cmd.wr ? entry_index : mid_sum[stbs_pkg::IDX_W:1];

  // Search registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r   <= key_value;
      count_r <= count_sat;
      empty_r <= (count_sat == '0);
    end
    if (cmd.load || cmd.step) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      mid_r   <= ram_addr;
    end
  end

  // Result registers, held until the next search ends.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      found_r    <= sts.hit;
      position_r <= sts.hit ? {1'b0, mid_r} : count_r;
    end
  end

  assign found    = found_r;
  assign position = position_r;

  stbs_ram #(
    .WIDTH (stbs_pkg::KEY_WIDTH),
    .DEPTH (stbs_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr),
    .addr  (ram_addr),
    .wdata (key_value),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

>>> rtl/sorted_table_binary_search.sv
// Top level of the sorted-table binary search block.
// Depends on stbs_pkg; instantiates stbs_ctrl and stbs_dp.
//
// Usage:
//   An input beat is taken on a rising edge with start high and busy low.
//   in_command selects a table write (CMD_WRITE) or a search (CMD_SEARCH).
//   A write stores in_key_value at in_entry_index; busy stays low and no
//   result is produced. A search raises busy and probes the table RAM once
//   per cycle at the midpoint of the current bounds; the single RAM read
//   port sets this rate. The result beat appears on out_found and
//   out_position with out_strobe high for one cycle, in the cycle busy
//   falls. A new beat may be started in that same cycle. The receiver
//   cannot stall; results are not held back. cfg_wr_en loads the entry
//   count (cfg_wr_data); the user must assert it only while the block is
//   idle, which the block itself does not enforce. Reset clears the
//   controller and sets the entry count to 256; the table contents are
//   undefined until written.
`default_nettype none

module sorted_table_binary_search (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_command,
  input  wire logic [stbs_pkg::IDX_W-1:0]      in_entry_index,
  input  wire logic [stbs_pkg::KEY_WIDTH-1:0]  in_key_value,
  output logic                                 out_strobe,
  output logic                                 out_found,
  output logic [stbs_pkg::CNT_W-1:0]           out_position,
  input  wire logic                            cfg_wr_en,
  input  wire logic [stbs_pkg::CNT_W-1:0]      cfg_wr_data
);

  stbs_pkg::stbs_cmd_t cmd;
  stbs_pkg::stbs_sts_t sts;

  stbs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .command (in_command),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd),
    .strobe  (out_strobe)
  );

  stbs_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .entry_index (in_entry_index),
    .key_value   (in_key_value),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .found       (out_found),
    .position    (out_position)
  );

endmodule

`default_nettype wire

>>> rtl/stbs_checker.sv
// Port-level checker for the sorted-table binary search, bound to the top.
// Depends on stbs_pkg for the command codes.
`default_nettype none

module stbs_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic                            in_command,
  input wire logic                            out_strobe,
  input wire logic                            out_found,
  input wire logic [stbs_pkg::CNT_W-1:0]      out_position
);

  // An accepted search makes the block busy on the next cycle.
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == stbs_pkg::CMD_SEARCH)) |=> busy)
    else $error("search beat accepted but busy did not rise");

  // A result beat comes exactly when a search finishes.
  a_strobe_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe == (!busy && $past(busy)))
    else $error("result strobe does not match the end of a search");

  // A match always lies inside the table.
  a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_found) |->
      (out_position < stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH)))
    else $error("match position beyond the table");

  // A search never runs past the probe limit.
  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy && $past(busy, 1) && $past(busy, 2) && $past(busy, 3) &&
      $past(busy, 4) && $past(busy, 5) && $past(busy, 6) &&
      $past(busy, 7) && $past(busy, 8) && $past(busy, 9)))
    else $error("search exceeded the probe limit");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_command   (in_command),
  .out_strobe   (out_strobe),
  .out_found    (out_found),
  .out_position (out_position)
);

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for sorted_table_binary_search: table loads, searches and count changes.
// Predicts every search result from its own table copy and compares each result beat.
// Depends on stbs_pkg and the sorted_table_binary_search RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int TARGET_BEATS  = 1550;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_CYCLES    = 400000;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic                       found;
    logic [stbs_pkg::CNT_W-1:0] position;
  } search_result_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              in_command = stbs_pkg::CMD_WRITE;
  logic [stbs_pkg::IDX_W-1:0]        in_entry_index = '0;
  logic [stbs_pkg::KEY_WIDTH-1:0]    in_key_value = '0;
  logic                              out_strobe;
  logic                              out_found;
  logic [stbs_pkg::CNT_W-1:0]        out_position;
  logic                              cfg_wr_en = 1'b0;
  logic [stbs_pkg::CNT_W-1:0]        cfg_wr_data = '0;

  // Shadow of the block state as seen from the ports.
  logic [stbs_pkg::KEY_WIDTH-1:0]    key_table [stbs_pkg::TABLE_DEPTH];
  logic [stbs_pkg::CNT_W-1:0]        entry_count = 9'd256;
  search_result_t                    expected_results [$];

  int  beats_sent = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  gaps_on = 1'b1;

  sorted_table_binary_search dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_entry_index (in_entry_index),
    .in_key_value   (in_key_value),
    .out_strobe     (out_strobe),
    .out_found      (out_found),
    .out_position   (out_position),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Runaway guard for a hung handshake or a lost result.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Midpoint binary search over the shadow table, exactly as the block probes it.
  function automatic search_result_t predict_search(input logic [stbs_pkg::KEY_WIDTH-1:0] key);
    search_result_t res;
    int unsigned    span;
    int unsigned    lo;
    int unsigned    hi;
    int unsigned    mid;
    span = (entry_count > stbs_pkg::TABLE_DEPTH) ? stbs_pkg::TABLE_DEPTH : entry_count;
    res.found = 1'b0;
    res.position = span[stbs_pkg::CNT_W-1:0];
    if (span == 0) return res;
    lo = 0;
    hi = span - 1;
    while (lo != hi) begin
      mid = (lo + hi) / 2;
      if (key_table[mid] == key) begin
        res.found = 1'b1;
        res.position = mid[stbs_pkg::CNT_W-1:0];
        return res;
      end
      if (key_table[mid] > key) begin
        // Stepping left of the lower bound means the key is absent.
        if (lo == mid) return res;
        hi = mid - 1;
      end else begin
        if (mid == hi) return res;
        lo = mid + 1;
      end
    end
    if (key_table[lo] == key) begin
      res.found = 1'b1;
      res.position = lo[stbs_pkg::CNT_W-1:0];
    end
    return res;
  endfunction

  // Compare every result beat with the oldest pending prediction.
  always @(posedge clk) begin
    search_result_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("Unexpected result beat: found=%0b position=%0d", out_found, out_position);
      end else begin
        want = expected_results.pop_front();
        if (out_found !== want.found || out_position !== want.position) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("Result mismatch: expected found=%0b position=%0d, got found=%0b position=%0d",
                     want.found, want.position, out_found, out_position);
        end
      end
    end
  end

  // Send one input beat after a random gap; start stays high when the next beat follows at once.
  task automatic send_beat(input logic cmd, input logic [stbs_pkg::IDX_W-1:0] idx,
                           input logic [stbs_pkg::KEY_WIDTH-1:0] key);
    int gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_command     <= cmd;
    in_entry_index <= idx;
    in_key_value   <= key;
    do @(posedge clk); while (busy);
    beats_sent++;
    if (cmd == stbs_pkg::CMD_WRITE)
      key_table[idx] = key;
    else
      expected_results.push_back(predict_search(key));
  endtask

  // Change the entry count only once the block has drained.
  task automatic write_entry_count(input logic [stbs_pkg::CNT_W-1:0] value);
    start <= 1'b0;
    while (expected_results.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    entry_count = value;
    cfg_wr_en <= 1'b0;
  endtask

  // Fill entries 0..n-1 with an ascending run (duplicates included) or with random keys.
  task automatic load_sorted_run(input int n, input bit scrambled);
    logic [32:0] acc;
    int          step_bits;
    step_bits = $urandom_range(0, 28);
    acc = ($urandom_range(0, 3) == 0) ? 33'd0 : {1'b0, $urandom} >> $urandom_range(0, 31);
    for (int i = 0; i < n; i++) begin
      if (scrambled)
        send_beat(stbs_pkg::CMD_WRITE, i[stbs_pkg::IDX_W-1:0], $urandom);
      else
        send_beat(stbs_pkg::CMD_WRITE, i[stbs_pkg::IDX_W-1:0],
                  acc[32] ? 32'hFFFF_FFFF : acc[31:0]);
      // Once past the top the run stays at the largest key.
      if (!acc[32])
        acc = acc + ({1'b0, $urandom} >> (32 - step_bits));
    end
  endtask

  // Empty and tiny tables, boundary exits, duplicates and an unsorted table.
  task automatic test_small_tables();
    write_entry_count(9'd0);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, 32'h0);
    write_entry_count(9'd1);
    send_beat(stbs_pkg::CMD_WRITE, 8'd0, 32'h55);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, 32'h55);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, 32'h54);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, 32'h56);
    write_entry_count(9'd5);
    send_beat(stbs_pkg::CMD_WRITE, 8'd0, 32'h0);
    send_beat(stbs_pkg::CMD_WRITE, 8'd1, 32'h7);
    send_beat(stbs_pkg::CMD_WRITE, 8'd2, 32'h7);
    send_beat(stbs_pkg::CMD_WRITE, 8'd3, 32'h64);
    send_beat(stbs_pkg::CMD_WRITE, 8'd4, 32'hFFFF_FFFF);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, 32'h0);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, 32'h7);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, 32'h32);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, 32'hFFFF_FFFF);
    // Keys below the first and above the last entry leave through the bounds.
    write_entry_count(9'd4);
    send_beat(stbs_pkg::CMD_WRITE, 8'd0, 32'd10);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, 32'd5);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, 32'd200);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, 32'd100);
    // Unsorted contents still follow the same probe order.
    send_beat(stbs_pkg::CMD_WRITE, 8'd1, 32'hFFFF_FFF0);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, 32'd7);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, 32'hFFFF_FFF0);
  endtask

  // Full-depth table, with the count at the depth, just under it and saturated above it.
  task automatic test_full_table();
    write_entry_count(9'd256);
    load_sorted_run(stbs_pkg::TABLE_DEPTH, 1'b0);
    send_beat(stbs_pkg::CMD_WRITE, 8'd0, 32'h0);
    send_beat(stbs_pkg::CMD_WRITE, 8'd255, 32'hFFFF_FFFF);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, key_table[0]);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, key_table[255]);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, key_table[100]);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, key_table[100] + 32'd1);
    write_entry_count(9'd511);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, 32'hFFFF_FFFF);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, key_table[37] ^ 32'h1);
    write_entry_count(9'd257);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, key_table[200]);
    write_entry_count(9'd255);
    send_beat(stbs_pkg::CMD_SEARCH, 8'd0, 32'hFFFF_FFFF);
  endtask

  // Random phases: new count, usually a fresh sorted run, then searches with a little noise.
  task automatic test_random_sweeps();
    int          count;
    int          span;
    int          searches;
    logic [31:0] key;
    while (beats_sent < TARGET_BEATS) begin
      case ($urandom_range(0, 15))
        0:       count = 0;
        1:       count = $urandom_range(257, 511);
        2, 3:    count = $urandom_range(49, 256);
        default: count = $urandom_range(1, 48);
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      write_entry_count(count[stbs_pkg::CNT_W-1:0]);
      span = (count > stbs_pkg::TABLE_DEPTH) ? stbs_pkg::TABLE_DEPTH : count;
      if (span != 0 && (span <= 48 || $urandom_range(0, 3) == 0))
        load_sorted_run(span, $urandom_range(0, 7) == 0);
      searches = $urandom_range(8, 40);
      repeat (searches) begin
        if ($urandom_range(0, 15) == 0) begin
          send_beat(stbs_pkg::CMD_WRITE, stbs_pkg::IDX_W'($urandom_range(0, 255)), $urandom);
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: key = (span != 0) ? key_table[$urandom_range(0, span - 1)] : $urandom;
            5:             key = (span != 0) ? key_table[$urandom_range(0, span - 1)] + 32'd1
                                             : 32'h0;
            6:             key = (span != 0) ? key_table[$urandom_range(0, span - 1)] - 32'd1
                                             : 32'hFFFF_FFFF;
            7:             key = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            default:       key = $urandom;
          endcase
          send_beat(stbs_pkg::CMD_SEARCH, stbs_pkg::IDX_W'($urandom_range(0, 255)), key);
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_small_tables();
    test_full_table();
    test_random_sweeps();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sorted_table_binary_search.f
rtl/stbs_pkg.sv
rtl/stbs_ram.sv
rtl/stbs_ctrl.sv
rtl/stbs_dp.sv
rtl/sorted_table_binary_search.sv
rtl/stbs_checker.sv
tb/sv/tb_top.sv
